/* src/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define KWG_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("kwg check failed");

// Check that a condition implies another in the same cycle.
`define KWG_IMPLY(lbl, a, b) `KWG_ASSERT(lbl, (a) |-> (b))

`endif

/* src/kwg_pkg.sv */
package kwg_pkg;

	// Default geometry
	localparam int NUM_KEYS_DEF       = 64;
	localparam int MAX_NEIGHBOURS_DEF = 8;
	localparam int MAX_DEPTH_DEF      = 8;
	localparam int STACK_DEPTH_DEF    = 256;

	// Fixed field widths
	localparam int KEY_W  = 6;
	localparam int CHAR_W = 8;
	localparam int LEN_W  = 4;
	localparam int NNB_W  = 5;
	localparam int WORD_W = 64;

	// Actions
	localparam logic [1:0] ACT_KEY   = 2'd0;
	localparam logic [1:0] ACT_NB    = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;
	localparam logic [1:0] ACT_NEXT  = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_ACCEPT = 3'd0;
	localparam logic [2:0] ST_WORD   = 3'd1;
	localparam logic [2:0] ST_DONE   = 3'd2;
	localparam logic [2:0] ST_OVF    = 3'd3;
	localparam logic [2:0] ST_INACT  = 3'd4;

	// Configuration register indexes
	localparam logic CFG_MIN = 1'b0;
	localparam logic CFG_MAX = 1'b1;

	// Key table address select
	localparam logic [1:0] KSEL_IN  = 2'd0;
	localparam logic [1:0] KSEL_ENT = 2'd1;
	localparam logic [1:0] KSEL_NB  = 2'd2;
	localparam logic [1:0] KSEL_PK  = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [KEY_W-1:0]  key_index;
		logic [CHAR_W-1:0] base_char;
		logic [1:0]        variant_count;
		logic [CHAR_W-1:0] variant_first;
		logic [CHAR_W-1:0] variant_second;
		logic              key_active;
		logic [3:0]        neighbour_total;
		logic [2:0]        slot;
		logic [KEY_W-1:0]  neighbour_key;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [WORD_W-1:0] word_chars;
		logic [LEN_W-1:0]  word_length;
	} out_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] base;
		logic [CHAR_W-1:0] var1;
		logic [CHAR_W-1:0] var2;
		logic [1:0]        nvar;
		logic              act;
		logic [NNB_W-1:0]  nnb;
	} key_ent_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] depth;
		logic [1:0]       kind;
		logic             visited;
	} stk_ent_t;

	// Controller to datapath
	typedef struct packed {
		logic       load_in;
		logic       key_wr;
		logic       nb_wr;
		logic       clr_top;
		logic       pop;
		logic       mark;
		logic [1:0] ksel;
		logic       char_ld;
		logic       cnt_clr;
		logic       cnt_add;
		logic       i_inc;
		logic       push_in;
		logic       push_nb;
		logic       push_var;
		logic       emit;
		logic [2:0] status;
		logic       word;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] action;
		logic       top_zero;
		logic       ent_visited;
		logic       ent_bad;
		logic       ge_max;
		logic       ge_min;
		logic       len_ge_min;
		logic       i_lt;
		logic       nb_use;
		logic       start_ok;
		logic       ovf;
		logic       pv_more;
		logic       out_free;
	} sts_t;

endpackage

/* src/kwg_ctrl.sv */
module kwg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  kwg_pkg::sts_t   sts,
	output kwg_pkg::cmd_t   cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_SC    = 4'd2;
	localparam logic [3:0] S_TOP   = 4'd3;
	localparam logic [3:0] S_ENT   = 4'd4;
	localparam logic [3:0] S_CHAR  = 4'd5;
	localparam logic [3:0] S_CNTA  = 4'd6;
	localparam logic [3:0] S_CNTB  = 4'd7;
	localparam logic [3:0] S_CNTC  = 4'd8;
	localparam logic [3:0] S_CHK   = 4'd9;
	localparam logic [3:0] S_EXPA  = 4'd10;
	localparam logic [3:0] S_EXPB  = 4'd11;
	localparam logic [3:0] S_EXPC  = 4'd12;
	localparam logic [3:0] S_PV    = 4'd13;
	localparam logic [3:0] S_EMIT  = 4'd14;

	logic [3:0] state_q, state_d;
	logic [2:0] st_q, st_d;
	logic       word_q, word_d;
	logic       ret_q, ret_d;

	assign in_stall = (state_q != S_IDLE);

	// Sequence one item
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		word_d  = word_q;
		ret_d   = ret_q;
		cmd     = '0;
		cmd.ksel = kwg_pkg::KSEL_IN;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				st_d   = kwg_pkg::ST_ACCEPT;
				word_d = 1'b0;
				case (sts.action)
					kwg_pkg::ACT_KEY: begin
						cmd.key_wr = 1'b1;
						state_d = S_EMIT;
					end
					kwg_pkg::ACT_NB: begin
						cmd.nb_wr = 1'b1;
						state_d = S_EMIT;
					end
					kwg_pkg::ACT_START: begin
						cmd.clr_top = 1'b1;
						state_d = S_SC;
					end
					default: state_d = S_TOP;
				endcase
			end
			S_SC: begin
				if (!sts.start_ok) begin
					st_d = kwg_pkg::ST_INACT;
					state_d = S_EMIT;
				end else begin
					cmd.push_in = 1'b1;
					ret_d = 1'b1;
					state_d = S_PV;
				end
			end
			S_TOP: begin
				if (sts.top_zero) begin
					st_d = kwg_pkg::ST_DONE;
					state_d = S_EMIT;
				end else begin
					state_d = S_ENT;
				end
			end
			S_ENT: begin
				cmd.ksel = kwg_pkg::KSEL_ENT;
				if (sts.ent_visited || sts.ent_bad) begin
					cmd.pop = 1'b1;
					state_d = S_TOP;
				end else begin
					cmd.mark = 1'b1;
					state_d = S_CHAR;
				end
			end
			S_CHAR: begin
				cmd.char_ld = 1'b1;
				cmd.cnt_clr = 1'b1;
				if (sts.ge_max) begin
					cmd.pop = 1'b1;
					if (sts.ge_min) begin
						st_d = kwg_pkg::ST_WORD;
						word_d = 1'b1;
						state_d = S_EMIT;
					end else begin
						state_d = S_TOP;
					end
				end else begin
					state_d = S_CNTA;
				end
			end
			S_CNTA: state_d = sts.i_lt ? S_CNTB : S_CHK;
			S_CNTB: begin
				cmd.ksel = kwg_pkg::KSEL_NB;
				state_d = S_CNTC;
			end
			S_CNTC: begin
				cmd.ksel = kwg_pkg::KSEL_NB;
				cmd.cnt_add = 1'b1;
				state_d = S_CNTA;
			end
			S_CHK: begin
				cmd.cnt_clr = 1'b1;
				if (sts.ovf) begin
					cmd.clr_top = 1'b1;
					st_d = kwg_pkg::ST_OVF;
					word_d = 1'b1;
					state_d = S_EMIT;
				end else begin
					state_d = S_EXPA;
				end
			end
			S_EXPA: begin
				if (sts.i_lt) begin
					state_d = S_EXPB;
				end else if (sts.len_ge_min) begin
					st_d = kwg_pkg::ST_WORD;
					word_d = 1'b1;
					state_d = S_EMIT;
				end else begin
					state_d = S_TOP;
				end
			end
			S_EXPB: begin
				cmd.ksel = kwg_pkg::KSEL_NB;
				state_d = S_EXPC;
			end
			S_EXPC: begin
				cmd.ksel = kwg_pkg::KSEL_NB;
				cmd.i_inc = 1'b1;
				if (sts.nb_use) begin
					cmd.push_nb = 1'b1;
					ret_d = 1'b0;
					state_d = S_PV;
				end else begin
					state_d = S_EXPA;
				end
			end
			S_PV: begin
				cmd.ksel = kwg_pkg::KSEL_PK;
				if (sts.pv_more) begin
					cmd.push_var = 1'b1;
				end else begin
					state_d = ret_q ? S_EMIT : S_EXPA;
				end
			end
			S_EMIT: begin
				cmd.status = st_q;
				cmd.word = word_q;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= kwg_pkg::ST_ACCEPT;
			word_q <= 1'b0;
			ret_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
			word_q <= word_d;
			ret_q <= ret_d;
		end
	end

endmodule

/* src/kwg_dp.sv */
module kwg_dp #(
	parameter int NUM_KEYS       = kwg_pkg::NUM_KEYS_DEF,
	parameter int MAX_NEIGHBOURS = kwg_pkg::MAX_NEIGHBOURS_DEF,
	parameter int MAX_DEPTH      = kwg_pkg::MAX_DEPTH_DEF,
	parameter int STACK_DEPTH    = kwg_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kwg_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output kwg_pkg::out_item_t  out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [3:0]          cfg_data,
	input  kwg_pkg::cmd_t       cmd,
	output kwg_pkg::sts_t       sts
);

	localparam int KW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int SW   = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int NBD  = NUM_KEYS * (2 ** SW);
	localparam int SAW  = $clog2(STACK_DEPTH);
	localparam int TW   = $clog2(STACK_DEPTH + 1);
	localparam int NDW  = $clog2(3 * MAX_NEIGHBOURS + 1);
	localparam int DW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	kwg_pkg::in_item_t in_q;
	logic [3:0] min_q, max_q;
	logic [3:0] maxd, mind;

	kwg_pkg::key_ent_t kmem [NUM_KEYS];
	logic [kwg_pkg::KEY_W-1:0] nmem [NBD];
	kwg_pkg::stk_ent_t smem [STACK_DEPTH];

	kwg_pkg::key_ent_t krd_q;
	logic [kwg_pkg::KEY_W-1:0] nbrd_q;
	kwg_pkg::stk_ent_t ent_q;
	logic [TW-1:0] top_q;
	logic [kwg_pkg::KEY_W-1:0] cur_key_q, pk_q;
	logic [kwg_pkg::NNB_W-1:0] cur_nnb_q, i_q;
	logic [kwg_pkg::LEN_W-1:0] len_q, pd_q;
	logic [NDW-1:0] need_q;
	logic [1:0] pv_q;
	logic [kwg_pkg::CHAR_W-1:0] wbuf_q [MAX_DEPTH];

	logic [kwg_pkg::KEY_W-1:0] kaddr;
	logic [TW-1:0] top_m1;
	logic [kwg_pkg::LEN_W-1:0] ent_len;
	logic [kwg_pkg::NNB_W-1:0] nt_clamp;
	logic [kwg_pkg::CHAR_W-1:0] ent_char;
	logic push_en;
	kwg_pkg::stk_ent_t push_ent;
	logic [kwg_pkg::WORD_W-1:0] word_pk;

	function automatic logic key_ok(input logic [kwg_pkg::KEY_W-1:0] k);
		return 32'(k) < NUM_KEYS;
	endfunction

	// Clamp the length registers
	always_comb begin
		maxd = max_q;
		if (maxd < 4'd1) maxd = 4'd1;
		if (32'(maxd) > MAX_DEPTH) maxd = 4'(MAX_DEPTH);
		mind = min_q;
		if (mind < 4'd1) mind = 4'd1;
		if (mind > maxd) mind = maxd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 4'd1;
			max_q <= 4'd8;
		end else if (cfg_we) begin
			if (cfg_index == kwg_pkg::CFG_MIN) min_q <= cfg_data;
			else max_q <= cfg_data;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= in_item;
	end

	// Key table
	always_comb begin
		case (cmd.ksel)
			kwg_pkg::KSEL_IN:  kaddr = in_q.key_index;
			kwg_pkg::KSEL_ENT: kaddr = ent_q.key;
			kwg_pkg::KSEL_NB:  kaddr = nbrd_q;
			default:           kaddr = pk_q;
		endcase
		nt_clamp = (32'(in_q.neighbour_total) > MAX_NEIGHBOURS) ?
			kwg_pkg::NNB_W'(MAX_NEIGHBOURS) : kwg_pkg::NNB_W'(in_q.neighbour_total);
	end

	always_ff @(posedge clk) begin
		if (cmd.key_wr && key_ok(in_q.key_index)) begin
			kmem[KW'(in_q.key_index)] <= '{
				base: in_q.base_char,
				var1: in_q.variant_first,
				var2: in_q.variant_second,
				nvar: (in_q.variant_count == 2'd3) ? 2'd2 : in_q.variant_count,
				act:  in_q.key_active,
				nnb:  nt_clamp};
		end
		krd_q <= kmem[KW'(kaddr)];
	end

	// Neighbour table
	always_ff @(posedge clk) begin
		if (cmd.nb_wr && key_ok(in_q.key_index) && 32'(in_q.slot) < MAX_NEIGHBOURS)
			nmem[{KW'(in_q.key_index), SW'(in_q.slot)}] <= in_q.neighbour_key;
		nbrd_q <= nmem[{KW'(cur_key_q), SW'(i_q)}];
	end

	// Walk stack
	assign top_m1 = top_q - TW'(1);
	assign push_en = (cmd.push_in || cmd.push_nb || cmd.push_var) &&
		(32'(top_q) < STACK_DEPTH);

	always_comb begin
		push_ent = '{key: pk_q, depth: pd_q, kind: pv_q, visited: 1'b0};
		if (cmd.push_in)
			push_ent = '{key: in_q.key_index, depth: '0, kind: 2'd0, visited: 1'b0};
		else if (cmd.push_nb)
			push_ent = '{key: nbrd_q, depth: len_q, kind: 2'd0, visited: 1'b0};
	end

	always_ff @(posedge clk) begin
		if (push_en)
			smem[SAW'(top_q)] <= push_ent;
		else if (cmd.mark)
			smem[SAW'(top_m1)] <= '{key: ent_q.key, depth: ent_q.depth,
				kind: ent_q.kind, visited: 1'b1};
		ent_q <= smem[SAW'(top_m1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (cmd.clr_top) begin
			top_q <= '0;
		end else if (cmd.pop) begin
			top_q <= top_m1;
		end else if (push_en) begin
			top_q <= top_q + TW'(1);
		end
	end

	// Push sequencing for variants
	always_ff @(posedge clk) begin
		if (cmd.push_in || cmd.push_nb) begin
			pk_q <= push_ent.key;
			pd_q <= push_ent.depth;
			pv_q <= 2'd1;
		end else if (cmd.push_var) begin
			pv_q <= pv_q + 2'd1;
		end
	end

	// Current entry, neighbour counter and count of pushes needed
	assign ent_len = ent_q.depth + 4'd1;
	always_comb begin
		case (ent_q.kind)
			2'd0:    ent_char = krd_q.base;
			2'd2:    ent_char = krd_q.var2;
			default: ent_char = krd_q.var1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.char_ld) begin
			cur_key_q <= ent_q.key;
			cur_nnb_q <= krd_q.nnb;
			len_q <= ent_len;
		end
		if (cmd.cnt_clr) begin
			i_q <= '0;
			if (cmd.char_ld) need_q <= '0;
		end else if (cmd.cnt_add || cmd.i_inc) begin
			i_q <= i_q + kwg_pkg::NNB_W'(1);
			if (cmd.cnt_add && sts.nb_use)
				need_q <= need_q + NDW'(krd_q.nvar) + NDW'(1);
		end
	end

	// Word buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < MAX_DEPTH; p++) wbuf_q[p] <= '0;
		end else if (cmd.char_ld) begin
			wbuf_q[DW'(ent_q.depth)] <= ent_char;
		end
	end

	always_comb begin
		word_pk = '0;
		for (int p = 0; p < 8; p++) begin
			if (p < MAX_DEPTH && 32'(len_q) > p)
				word_pk[8*p +: 8] = wbuf_q[p];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item.status <= cmd.status;
			out_item.word_chars <= cmd.word ? word_pk : '0;
			out_item.word_length <= cmd.word ? len_q : '0;
		end
	end

	// Status to controller
	always_comb begin
		sts.action      = in_q.action;
		sts.top_zero    = (top_q == '0);
		sts.ent_visited = ent_q.visited;
		sts.ent_bad     = (32'(ent_q.depth) >= MAX_DEPTH) || !key_ok(ent_q.key);
		sts.ge_max      = ent_len >= maxd;
		sts.ge_min      = ent_len >= mind;
		sts.len_ge_min  = len_q >= mind;
		sts.i_lt        = i_q < cur_nnb_q;
		sts.nb_use      = key_ok(nbrd_q) && krd_q.act;
		sts.start_ok    = key_ok(in_q.key_index) && krd_q.act;
		sts.ovf         = (32'(top_q) + 32'(need_q)) > STACK_DEPTH;
		sts.pv_more     = pv_q <= krd_q.nvar;
		sts.out_free    = !out_valid || !out_stall;
	end

endmodule

/* src/keyboard_walk_word_generator.sv */
// Keyboard walk word generator. Write keys and neighbour slots, start a walk
// from a key, then request words one at a time; each result carries a status
// and, for a word or an overflow, the characters reached. A table write is
// done between taking the item and handing out its result. A start clears
// the stack, checks the start key and pushes it and each of its variants. A
// next request runs a sequencer over single-ported key, neighbour and stack
// memories: each popped entry is read and dropped or marked, and an expanded
// entry loads its character, counts the pushes its neighbour slots need,
// checks for overflow, then walks the slots again and pushes each active
// neighbour with its variants, so the time a request takes grows with the
// number of entries popped before a word is found. Reset clears no table.
module keyboard_walk_word_generator #(
	parameter int NUM_KEYS       = kwg_pkg::NUM_KEYS_DEF,
	parameter int MAX_NEIGHBOURS = kwg_pkg::MAX_NEIGHBOURS_DEF,
	parameter int MAX_DEPTH      = kwg_pkg::MAX_DEPTH_DEF,
	parameter int STACK_DEPTH    = kwg_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  kwg_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output kwg_pkg::out_item_t  out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [3:0]          cfg_data
);

	kwg_pkg::cmd_t cmd;
	kwg_pkg::sts_t sts;

	kwg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	kwg_dp #(
		.NUM_KEYS       (NUM_KEYS),
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS),
		.MAX_DEPTH      (MAX_DEPTH),
		.STACK_DEPTH    (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* src/kwg_chk.sv */
`include "assert_macros.svh"

module kwg_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input kwg_pkg::out_item_t out_item,
	input logic               out_valid,
	input logic               out_stall
);

	// A waiting result stays put
	`KWG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
	`KWG_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_item))
	// The block is busy right after taking an item
	`KWG_ASSERT(a_busy, in_valid && !in_stall |=> in_stall)
	// Only words and overflows carry characters
	`KWG_IMPLY(a_no_word, out_valid && out_item.status != kwg_pkg::ST_WORD &&
		out_item.status != kwg_pkg::ST_OVF, out_item.word_length == '0)
	`KWG_IMPLY(a_word_len, out_valid && out_item.status == kwg_pkg::ST_WORD,
		out_item.word_length != '0)

endmodule

bind keyboard_walk_word_generator kwg_chk u_kwg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_item  (out_item),
	.out_valid (out_valid),
	.out_stall (out_stall)
);

/* tb/tb.sv */
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_KEYS    = 64;
	localparam int N_SLOTS   = 8;
	localparam int WALK_MAX  = 8;
	localparam int STACK_MAX = 256;
	localparam int CYCLE_LIMIT = 4_000_000;

	typedef struct {
		int key;
		int depth;
		int kind;
		bit visited;
	} frame_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	kwg_pkg::in_item_t in_item;
	logic out_valid;
	logic out_stall;
	kwg_pkg::out_item_t out_item;
	logic cfg_we;
	logic cfg_index;
	logic [3:0] cfg_data;

	keyboard_walk_word_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted block state
	logic [7:0] pk_base [N_KEYS];
	logic [7:0] pk_var1 [N_KEYS];
	logic [7:0] pk_var2 [N_KEYS];
	int pk_nvar [N_KEYS];
	bit pk_act [N_KEYS];
	int pk_nnb [N_KEYS];
	int pk_nb [N_KEYS][N_SLOTS];
	frame_t walk [STACK_MAX];
	int walk_top;
	logic [7:0] word_buf [WALK_MAX];
	int min_len;
	int max_len;

	// Stimulus-side view of which neighbour slots hold data
	logic [N_SLOTS-1:0] slots_loaded [N_KEYS];

	kwg_pkg::in_item_t pending_q [$];
	kwg_pkg::out_item_t word_q [$];
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	bit in_taken;
	int errors;
	int cycles;
	int n_items;
	int n_words;
	int n_exhausted;
	int n_inactive;
	int n_overflow;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic kwg_pkg::out_item_t make_result(logic [2:0] st, int len);
		kwg_pkg::out_item_t r;
		r.status = st;
		r.word_chars = '0;
		r.word_length = len[3:0];
		for (int p = 0; p < len; p++)
			r.word_chars[8*p +: 8] = word_buf[p];
		return r;
	endfunction

	function automatic void push_frames(int k, int depth);
		if (walk_top < STACK_MAX) begin
			walk[walk_top] = '{k, depth, 0, 1'b0};
			walk_top++;
		end
		for (int v = 0; v < pk_nvar[k]; v++)
			if (walk_top < STACK_MAX) begin
				walk[walk_top] = '{k, depth, v + 1, 1'b0};
				walk_top++;
			end
	endfunction

	// Pop and expand until a word, overflow or exhaustion
	function automatic kwg_pkg::out_item_t next_word();
		int maxd;
		int mind;
		int k;
		int d;
		int len;
		int need;
		maxd = (max_len < 1) ? 1 : (max_len > WALK_MAX) ? WALK_MAX : max_len;
		mind = (min_len < 1) ? 1 : (min_len > maxd) ? maxd : min_len;
		while (walk_top > 0) begin
			if (walk[walk_top-1].visited) begin
				walk_top--;
				continue;
			end
			walk[walk_top-1].visited = 1'b1;
			k = walk[walk_top-1].key;
			d = walk[walk_top-1].depth;
			if (d >= WALK_MAX) begin
				walk_top--;
				continue;
			end
			case (walk[walk_top-1].kind)
				0: word_buf[d] = pk_base[k];
				1: word_buf[d] = pk_var1[k];
				default: word_buf[d] = pk_var2[k];
			endcase
			len = d + 1;
			if (len >= maxd) begin
				walk_top--;
				if (len >= mind)
					return make_result(kwg_pkg::ST_WORD, len);
				continue;
			end
			need = 0;
			for (int i = 0; i < pk_nnb[k]; i++)
				if (pk_act[pk_nb[k][i]])
					need += 1 + pk_nvar[pk_nb[k][i]];
			if (walk_top + need > STACK_MAX) begin
				walk_top = 0;
				return make_result(kwg_pkg::ST_OVF, len);
			end
			for (int i = 0; i < pk_nnb[k]; i++)
				if (pk_act[pk_nb[k][i]])
					push_frames(pk_nb[k][i], len);
			if (len >= mind)
				return make_result(kwg_pkg::ST_WORD, len);
		end
		return make_result(kwg_pkg::ST_DONE, 0);
	endfunction

	function automatic kwg_pkg::out_item_t predict_item(kwg_pkg::in_item_t it);
		int k;
		k = it.key_index;
		case (it.action)
			kwg_pkg::ACT_KEY: begin
				pk_base[k] = it.base_char;
				pk_var1[k] = it.variant_first;
				pk_var2[k] = it.variant_second;
				pk_nvar[k] = (it.variant_count > 2) ? 2 : it.variant_count;
				pk_act[k] = it.key_active;
				pk_nnb[k] = (it.neighbour_total > N_SLOTS) ? N_SLOTS : it.neighbour_total;
			end
			kwg_pkg::ACT_NB: pk_nb[k][it.slot] = it.neighbour_key;
			kwg_pkg::ACT_START: begin
				walk_top = 0;
				if (!pk_act[k])
					return make_result(kwg_pkg::ST_INACT, 0);
				push_frames(k, 0);
			end
			default: return next_word();
		endcase
		return make_result(kwg_pkg::ST_ACCEPT, 0);
	endfunction

	// Count the run-in of loaded slots from slot 0
	function automatic int loaded_prefix(int k);
		int n;
		n = 0;
		while (n < N_SLOTS && slots_loaded[k][n])
			n++;
		return n;
	endfunction

	function automatic kwg_pkg::in_item_t random_fields();
		kwg_pkg::in_item_t it;
		it = kwg_pkg::in_item_t'({$urandom, $urandom});
		return it;
	endfunction

	function automatic kwg_pkg::in_item_t key_item(int k, bit act, int total);
		kwg_pkg::in_item_t it;
		it = random_fields();
		it.action = kwg_pkg::ACT_KEY;
		it.key_index = 6'(k);
		it.key_active = act;
		it.neighbour_total = 4'(total);
		return it;
	endfunction

	function automatic kwg_pkg::in_item_t slot_item(int k, int s, int nk);
		kwg_pkg::in_item_t it;
		it = random_fields();
		it.action = kwg_pkg::ACT_NB;
		it.key_index = 6'(k);
		it.slot = 3'(s);
		it.neighbour_key = 6'(nk);
		slots_loaded[k][s] = 1'b1;
		return it;
	endfunction

	function automatic kwg_pkg::in_item_t walk_item(logic [1:0] act, int k);
		kwg_pkg::in_item_t it;
		it = random_fields();
		it.action = act;
		it.key_index = 6'(k);
		return it;
	endfunction

	// Mostly walks with random content, some table updates in between
	function automatic kwg_pkg::in_item_t random_item();
		int pick;
		int k;
		int pfx;
		pick = $urandom_range(99);
		k = $urandom_range(N_KEYS - 1);
		pfx = loaded_prefix(k);
		if (pick < 8)
			return key_item(k, $urandom_range(99) < 75,
				(pfx == N_SLOTS) ? $urandom_range(15) : $urandom_range(pfx));
		if (pick < 20)
			return slot_item(k, (pfx < N_SLOTS && $urandom_range(1)) ?
				pfx : $urandom_range(N_SLOTS - 1), $urandom_range(N_KEYS - 1));
		if (pick < 30)
			return walk_item(kwg_pkg::ACT_START, k);
		return walk_item(kwg_pkg::ACT_NEXT, k);
	endfunction

	task automatic wait_idle(int settle);
		wait (pending_q.size() == 0 && !in_valid && word_q.size() == 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == kwg_pkg::CFG_MIN)
			min_len = val;
		else
			max_len = val;
	endtask

	// Drive input items
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_item <= pending_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Predict on accepted items, check accepted results
	always @(posedge clk) begin
		kwg_pkg::out_item_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				n_items++;
				word_q.push_back(predict_item(in_item));
			end
			if (out_valid && !out_stall) begin
				if (word_q.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, out_item);
					errors++;
				end else begin
					want = word_q.pop_front();
					case (want.status)
						kwg_pkg::ST_WORD: n_words++;
						kwg_pkg::ST_DONE: n_exhausted++;
						kwg_pkg::ST_INACT: n_inactive++;
						kwg_pkg::ST_OVF: n_overflow++;
						default: ;
					endcase
					if (out_item.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $realtime,
							want.status, out_item.status);
						errors++;
					end
					if (out_item.word_chars !== want.word_chars) begin
						$display("%0t: word_chars expected %h actual %h", $realtime,
							want.word_chars, out_item.word_chars);
						errors++;
					end
					if (out_item.word_length !== want.word_length) begin
						$display("%0t: word_length expected %0d actual %0d", $realtime,
							want.word_length, out_item.word_length);
						errors++;
					end
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				word_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int k;
		logic [3:0] mins [5];
		logic [3:0] maxs [5];
		mins = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd2};
		maxs = '{4'd8, 4'd0, 4'd15, 4'd5, 4'd1};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = kwg_pkg::CFG_MIN;
		cfg_data = '0;
		in_taken = 1'b0;
		hold_left = 0;
		errors = 0;
		cycles = 0;
		n_items = 0;
		n_words = 0;
		n_exhausted = 0;
		n_inactive = 0;
		n_overflow = 0;
		walk_top = 0;
		min_len = 1;
		max_len = 8;
		send_idle_pct = 38;
		recv_idle_pct = 59;
		for (int i = 0; i < N_KEYS; i++) begin
			slots_loaded[i] = '0;
			pk_act[i] = 1'b0;
			pk_nvar[i] = 0;
			pk_nnb[i] = 0;
		end
		for (int i = 0; i < WALK_MAX; i++)
			word_buf[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: next on empty stack, table load, extremes, inactive start
		pending_q.push_back(walk_item(kwg_pkg::ACT_NEXT, 0));
		for (int i = 0; i < N_KEYS; i++)
			pending_q.push_back(key_item(i, (i % 5) != 4, 0));
		for (int i = 0; i < 8; i++)
			for (int s = 0; s < N_SLOTS; s++)
				pending_q.push_back(slot_item(i, s, $urandom_range(N_KEYS - 1)));
		begin
			kwg_pkg::in_item_t it;
			it = key_item(0, 1'b1, 15);
			it.base_char = 8'h00;
			it.variant_count = 2'd3;
			it.variant_first = 8'hff;
			it.variant_second = 8'h00;
			pending_q.push_back(it);
			it = key_item(1, 1'b1, 8);
			it.base_char = 8'hff;
			it.variant_count = 2'd0;
			pending_q.push_back(it);
		end
		pending_q.push_back(walk_item(kwg_pkg::ACT_START, 4));
		pending_q.push_back(walk_item(kwg_pkg::ACT_NEXT, 0));
		pending_q.push_back(walk_item(kwg_pkg::ACT_START, 0));
		for (int i = 0; i < 6; i++)
			pending_q.push_back(walk_item(kwg_pkg::ACT_NEXT, i));
		wait_idle(20);

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(kwg_pkg::CFG_MIN, mins[ph]);
			write_reg(kwg_pkg::CFG_MAX, maxs[ph]);
			send_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 59 : 0;
			recv_idle_pct = (ph < 2) ? 59 : (ph < 4) ? 38 : 0;
			if (ph == 1)
				hold_left = 400;
			for (int i = 0; i < 320; i++)
				pending_q.push_back(random_item());
			// Let the walk run on from a fresh start
			k = $urandom_range(7);
			pending_q.push_back(walk_item(kwg_pkg::ACT_START, k));
			for (int i = 0; i < 20; i++)
				pending_q.push_back(walk_item(kwg_pkg::ACT_NEXT, k));
			wait_idle(20);
		end

		$display("%0d items in %0d cycles over 5 length settings", n_items, cycles);
		$display("%0d words, %0d exhausted, %0d inactive starts, %0d overflows",
			n_words, n_exhausted, n_inactive, n_overflow);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
